[sv/twac_pkg.sv]
// ----------------------------------------------------------------------------
// twac_pkg
// Shared types and constants for the time-window average with clip block.
// ----------------------------------------------------------------------------
package twac_pkg;

   // Field widths
   localparam int OPC_W    = 1;
   localparam int TIME_W   = 24;
   localparam int HR_W     = 8;
   localparam int PWR_W    = 12;
   localparam int SEC_W    = 20;
   localparam int SMOOTH_W = 10;
   localparam int FRAC_W   = 4;
   localparam int CSR_W    = 12;

   // Window storage
   localparam int WINDOW_DEPTH = 1024;
   localparam int PTR_W   = $clog2(WINDOW_DEPTH);
   localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int PTOT_W  = $clog2(WINDOW_DEPTH * ((1 << PWR_W) - 1) + 1);
   localparam int RTOT_W  = $clog2(WINDOW_DEPTH * ((1 << HR_W) - 1) + 1);

   // Division: a mean never exceeds the largest sample, so the quotient
   // fits the power width plus the fraction bits.
   localparam int QUO_W   = PWR_W + FRAC_W;
   localparam int NUM_W   = PTOT_W + FRAC_W;
   localparam int AVGP_W  = PWR_W + FRAC_W;
   localparam int AVGH_W  = HR_W + FRAC_W;

   localparam logic [SEC_W-1:0] WEEK_SECONDS = SEC_W'(7 * 24 * 60 * 60);

   localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = '0;
   localparam logic [HR_W-1:0]     MIN_HR_RESET = HR_W'(50);
   localparam logic [PWR_W-1:0]    MIN_P_RESET  = PWR_W'(50);
   localparam logic [PWR_W-1:0]    MAX_P_RESET  = PWR_W'(500);

   typedef enum logic [OPC_W-1:0] {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_SMOOTH_SECONDS = 2'd0,
      CSR_MIN_HEART_RATE = 2'd1,
      CSR_MIN_POWER      = 2'd2,
      CSR_MAX_POWER      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_EVICT_RD,
      ST_EVICT_CHK,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] sample_time;
      logic [PWR_W-1:0]  power;
      logic [HR_W-1:0]   heart_rate;
   } entry_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [TIME_W-1:0]  sample_time;
      logic [HR_W-1:0]    heart_rate;
      logic [PWR_W-1:0]   power;
      logic [SEC_W-1:0]   now_second;
   } req_item_type;

   typedef struct packed {
      logic take;
      logic pop;
      logic div_start;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic req_tick;
      logic range_ok;
      logic evict;
      logic empty;
      logic div_done;
      logic pass;
      logic out_free;
   } status_type;

endpackage

[sv/twac_if.sv]
// ----------------------------------------------------------------------------
// twac_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface twac_req_if;
   import twac_pkg::*;

   logic              valid;
   logic              ready;
   opcode_type        opcode;
   logic [TIME_W-1:0] sample_time;
   logic [HR_W-1:0]   heart_rate;
   logic [PWR_W-1:0]  power;
   logic [SEC_W-1:0]  now_second;

   modport source (
      output valid, opcode, sample_time, heart_rate, power, now_second,
      input  ready
   );
   modport sink (
      input  valid, opcode, sample_time, heart_rate, power, now_second,
      output ready
   );
endinterface

interface twac_rsp_if;
   import twac_pkg::*;

   logic              valid;
   logic              ready;
   logic [SEC_W-1:0]  out_second;
   logic [AVGP_W-1:0] avg_power;
   logic [AVGH_W-1:0] avg_heart_rate;
   logic              window_overflow;

   modport source (
      output valid, out_second, avg_power, avg_heart_rate, window_overflow,
      input  ready
   );
   modport sink (
      input  valid, out_second, avg_power, avg_heart_rate, window_overflow,
      output ready
   );
endinterface

[sv/twac_ram.sv]
// ----------------------------------------------------------------------------
// twac_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module twac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/twac_div.sv]
// ----------------------------------------------------------------------------
// twac_div
// Two-lane restoring divider sharing one step counter; one quotient bit per
// lane per cycle.
// ----------------------------------------------------------------------------
module twac_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [twac_pkg::NUM_W-1:0]  num_a,
   input  logic [twac_pkg::NUM_W-1:0]  num_b,
   input  logic [twac_pkg::CNT_W-1:0]  divisor,
   output logic                        done,
   output logic [twac_pkg::QUO_W-1:0]  quo_a,
   output logic [twac_pkg::QUO_W-1:0]  quo_b
);
   import twac_pkg::*;

   localparam int STEP_W = $clog2(QUO_W);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff [2];
   logic [CNT_W-1:0]  rem_in [2];
   logic [QUO_W-1:0]  quo_ff [2];
   logic [QUO_W-1:0]  quo_in [2];
   logic [NUM_W-1:0]  num [2];
   logic [CNT_W:0]    trial [2];
   logic              last;

   assign num[0] = num_a;
   assign num[1] = num_b;
   assign last   = busy_ff && (step_ff == STEP_W'(QUO_W - 1));

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + STEP_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         trial[i]  = {rem_ff[i], quo_ff[i][QUO_W-1]};
         rem_in[i] = rem_ff[i];
         quo_in[i] = quo_ff[i];
         if (start) begin
            // upper numerator bits are below the divisor when the quotient fits
            rem_in[i] = CNT_W'(num[i] >> QUO_W);
            quo_in[i] = num[i][QUO_W-1:0];
         end else if (busy_ff) begin
            if (trial[i] >= {1'b0, divisor}) begin
               rem_in[i] = CNT_W'(trial[i] - {1'b0, divisor});
               quo_in[i] = {quo_ff[i][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][CNT_W-1:0];
               quo_in[i] = {quo_ff[i][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      for (int i = 0; i < 2; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
      end
   end

   assign done  = last;
   assign quo_a = quo_ff[0];
   assign quo_b = quo_ff[1];

endmodule

[sv/twac_ctrl.sv]
// ----------------------------------------------------------------------------
// twac_ctrl
// Sequencer: accepts beats, walks eviction, runs the divider, loads results.
// ----------------------------------------------------------------------------
module twac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  twac_pkg::status_type   stat,
   output twac_pkg::cmd_type      cmd
);
   import twac_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.req_tick) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = stat.range_ok ? ST_EVICT_CHK : ST_IDLE;
         end
         ST_EVICT_RD: begin
            state_in = ST_EVICT_CHK;
         end
         ST_EVICT_CHK: begin
            if (stat.evict) begin
               state_in = ST_EVICT_RD;
            end else if (stat.empty) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!stat.pass || stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_EVICT_CHK: begin
            cmd.pop       = stat.evict;
            cmd.div_start = !stat.evict && !stat.empty;
         end
         ST_EMIT: begin
            cmd.load_out = stat.pass && stat.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/twac_dp.sv]
// ----------------------------------------------------------------------------
// twac_dp
// Datapath: window RAM, pointers, running sums, settings, divider and the
// result register.
// ----------------------------------------------------------------------------
module twac_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  twac_pkg::req_item_type        req_item,
   input  twac_pkg::cmd_type             cmd,
   output twac_pkg::status_type          stat,
   input  logic                          csr_we,
   input  twac_pkg::csr_index_type       csr_index,
   input  logic [twac_pkg::CSR_W-1:0]    csr_wdata,
   twac_rsp_if.source                    rsp
);
   import twac_pkg::*;

   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTOT_W-1:0]   ptot_ff, ptot_in;
   logic [RTOT_W-1:0]   rtot_ff, rtot_in;
   logic                ovf_ff, ovf_in;
   logic [SEC_W-1:0]    sec_ff, sec_in;

   logic [SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic [HR_W-1:0]     min_hr_ff, min_hr_in;
   logic [PWR_W-1:0]    min_p_ff, min_p_in;
   logic [PWR_W-1:0]    max_p_ff, max_p_in;

   logic                out_valid_ff, out_valid_in;
   logic [SEC_W-1:0]    out_sec_ff, out_sec_in;
   logic [AVGP_W-1:0]   out_avgp_ff, out_avgp_in;
   logic [AVGH_W-1:0]   out_avgh_ff, out_avgh_in;
   logic                out_ovf_ff, out_ovf_in;

   logic                push, full, wr_en;
   entry_type           wr_entry, rd_entry;
   logic [TIME_W-1:0]   limit;
   logic [QUO_W-1:0]    quo_p, quo_h;
   logic                div_done;

   assign full  = (count_ff == CNT_W'(WINDOW_DEPTH));
   assign push  = cmd.take && (req_item.opcode == OP_SAMPLE);
   assign wr_en = push && !full;

   assign wr_entry.sample_time = req_item.sample_time;
   assign wr_entry.power       = req_item.power;
   assign wr_entry.heart_rate  = req_item.heart_rate;

   twac_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   twac_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num_a   ({ptot_ff, FRAC_W'(0)}),
      .num_b   (NUM_W'({rtot_ff, FRAC_W'(0)})),
      .divisor (count_ff),
      .done    (div_done),
      .quo_a   (quo_p),
      .quo_b   (quo_h)
   );

   // oldest permitted timestamp, in sixteenths of a second
   assign limit = {sec_ff - SEC_W'(smooth_ff), FRAC_W'(0)};

   assign stat.req_tick = (req_item.opcode == OP_TICK);
   assign stat.range_ok = (sec_ff >= SEC_W'(smooth_ff)) && (sec_ff <= WEEK_SECONDS);
   assign stat.empty    = (count_ff == '0);
   assign stat.evict    = !stat.empty && (rd_entry.sample_time < limit);
   assign stat.div_done = div_done;
   assign stat.pass     = (quo_h >= QUO_W'({min_hr_ff, FRAC_W'(0)})) &&
                          (quo_p >= {min_p_ff, FRAC_W'(0)}) &&
                          (quo_p <  {max_p_ff, FRAC_W'(0)});
   assign stat.out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ptot_in  = ptot_ff;
      rtot_in  = rtot_ff;
      ovf_in   = ovf_ff;
      sec_in   = sec_ff;
      if (push) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            tail_in  = (tail_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
            count_in = count_ff + CNT_W'(1);
            ptot_in  = ptot_ff + PTOT_W'(req_item.power);
            rtot_in  = rtot_ff + RTOT_W'(req_item.heart_rate);
         end
      end
      if (cmd.take && (req_item.opcode == OP_TICK)) begin
         sec_in = req_item.now_second;
      end
      if (cmd.pop) begin
         head_in  = (head_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
         ptot_in  = ptot_ff - PTOT_W'(rd_entry.power);
         rtot_in  = rtot_ff - RTOT_W'(rd_entry.heart_rate);
      end
   end

   always_comb begin
      smooth_in = smooth_ff;
      min_hr_in = min_hr_ff;
      min_p_in  = min_p_ff;
      max_p_in  = max_p_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SMOOTH_SECONDS: smooth_in = csr_wdata[SMOOTH_W-1:0];
            CSR_MIN_HEART_RATE: min_hr_in = csr_wdata[HR_W-1:0];
            CSR_MIN_POWER:      min_p_in  = csr_wdata[PWR_W-1:0];
            CSR_MAX_POWER:      max_p_in  = csr_wdata[PWR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      out_sec_in   = out_sec_ff;
      out_avgp_in  = out_avgp_ff;
      out_avgh_in  = out_avgh_ff;
      out_ovf_in   = out_ovf_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_sec_in   = sec_ff;
         out_avgp_in  = quo_p;
         out_avgh_in  = quo_h[AVGH_W-1:0];
         out_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ptot_ff      <= '0;
         rtot_ff      <= '0;
         ovf_ff       <= 1'b0;
         smooth_ff    <= SMOOTH_RESET;
         min_hr_ff    <= MIN_HR_RESET;
         min_p_ff     <= MIN_P_RESET;
         max_p_ff     <= MAX_P_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         ptot_ff      <= ptot_in;
         rtot_ff      <= rtot_in;
         ovf_ff       <= ovf_in;
         smooth_ff    <= smooth_in;
         min_hr_ff    <= min_hr_in;
         min_p_ff     <= min_p_in;
         max_p_ff     <= max_p_in;
         out_valid_ff <= out_valid_in;
      end
      sec_ff      <= sec_in;
      out_sec_ff  <= out_sec_in;
      out_avgp_ff <= out_avgp_in;
      out_avgh_ff <= out_avgh_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.out_second      = out_sec_ff;
   assign rsp.avg_power       = out_avgp_ff;
   assign rsp.avg_heart_rate  = out_avgh_ff;
   assign rsp.window_overflow = out_ovf_ff;

endmodule

[sv/time_window_average_with_clip.sv]
// A sample beat is taken in the idle state. An in-range tick passes the start state,
// a check and a registered RAM read per evicted sample and, if samples remain, the
// divider (one quotient bit per cycle) and emit, where a passing mean waits for the
// result register. One beat at a time; the result register lets the next beat in.
// Reset (synchronous) empties the window, clears sums and the overflow flag and
// restores the default settings; no clearing pass over the RAM.
// ----------------------------------------------------------------------------
// time_window_average_with_clip
// Sliding time-window mean of power and heart rate with a pass band.
// ----------------------------------------------------------------------------
module time_window_average_with_clip (
   input  logic                          clock,
   input  logic                          reset,
   twac_req_if.sink                      req_ch,
   twac_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  twac_pkg::csr_index_type       csr_index,
   input  logic [twac_pkg::CSR_W-1:0]    csr_wdata
);
   import twac_pkg::*;

   cmd_type      cmd;
   status_type   stat;
   req_item_type req_item;

   assign req_item.opcode      = req_ch.opcode;
   assign req_item.sample_time = req_ch.sample_time;
   assign req_item.heart_rate  = req_ch.heart_rate;
   assign req_item.power       = req_ch.power;
   assign req_item.now_second  = req_ch.now_second;

   twac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   twac_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_ch)
   );

endmodule

[sv/twac_checker.sv]
// ----------------------------------------------------------------------------
// twac_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module twac_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [twac_pkg::SEC_W-1:0]  rsp_out_second
);
   import twac_pkg::*;

   // no result straight out of reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a new result only comes from a tick still in work, never from a beat
   // accepted in the cycle before
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result raised straight after an accepted beat");

   a_second_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_second <= WEEK_SECONDS)
      else $error("result second beyond one week");

endmodule

bind time_window_average_with_clip twac_checker u_twac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_second (rsp_ch.out_second)
);

[sim/time_window_average_with_clip_test.sv]
// ----------------------------------------------------------------------------
// time_window_average_with_clip_test
// Self-checking bench for the sliding time-window mean with pass band. A
// short table of hand-worked beats comes first, then random seconds of
// samples and ticks over several register settings. Every result beat is
// compared field by field against the table row or, after the table, against a
// behavioural copy of the window, sums and pass band kept in this module.
// ----------------------------------------------------------------------------
module time_window_average_with_clip_test;
   import twac_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // longest tick: a full window evicted, then the divider
   localparam int SETTLE_CYCLES   = 2 + 2 * WINDOW_DEPTH + 16 + 1 + 150;
   localparam int RSP_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [SEC_W-1:0]  second;
      logic [AVGP_W-1:0] avg_power;
      logic [AVGH_W-1:0] avg_heart_rate;
      logic              window_overflow;
   } mean_pair_type;

   typedef struct packed {
      req_item_type  beat;
      logic          emits;
      mean_pair_type mean;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   twac_req_if req_ch ();
   twac_rsp_if rsp_ch ();

   time_window_average_with_clip u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // window copy and settings
   logic [TIME_W-1:0]   win_time  [WINDOW_DEPTH];
   logic [PWR_W-1:0]    win_power [WINDOW_DEPTH];
   logic [HR_W-1:0]     win_rate  [WINDOW_DEPTH];
   int unsigned         win_head = 0;
   int unsigned         win_tail = 0;
   int unsigned         win_fill = 0;
   int unsigned         power_sum = 0;
   int unsigned         rate_sum = 0;
   bit                  overflowed = 1'b0;
   logic [SMOOTH_W-1:0] cfg_smooth = SMOOTH_RESET;
   logic [HR_W-1:0]     cfg_min_hr = MIN_HR_RESET;
   logic [PWR_W-1:0]    cfg_min_p  = MIN_P_RESET;
   logic [PWR_W-1:0]    cfg_max_p  = MAX_P_RESET;

   mean_pair_type       expected_means [$];
   stim_row_type        directed_rows [$];
   int unsigned         mismatches = 0;
   int unsigned         beats_sent = 0;
   int unsigned         second_now = 0;
   bit                  send_gaps = 1'b1;
   bit                  rsp_stalls = 1'b1;
   bit                  rsp_hold_pending = 1'b0;

   function automatic bit advance_window(input req_item_type beat,
                                         output mean_pair_type mean);
      int unsigned sec;
      int unsigned limit;
      int unsigned avg_p;
      int unsigned avg_h;
      mean = '0;
      if (beat.opcode == OP_SAMPLE) begin
         if (win_fill >= WINDOW_DEPTH) begin
            overflowed = 1'b1;
         end else begin
            win_time[win_tail]  = beat.sample_time;
            win_power[win_tail] = beat.power;
            win_rate[win_tail]  = beat.heart_rate;
            power_sum += beat.power;
            rate_sum  += beat.heart_rate;
            win_tail = (win_tail + 1) % WINDOW_DEPTH;
            win_fill++;
         end
         return 1'b0;
      end
      sec = beat.now_second;
      if (sec < cfg_smooth || sec > WEEK_SECONDS) return 1'b0;
      limit = (sec - cfg_smooth) * 16;
      // drop from the front only; later entries may be older
      while (win_fill != 0 && win_time[win_head] < limit) begin
         power_sum -= win_power[win_head];
         rate_sum  -= win_rate[win_head];
         win_head = (win_head + 1) % WINDOW_DEPTH;
         win_fill--;
      end
      if (win_fill == 0) return 1'b0;
      avg_p = power_sum * 16 / win_fill;
      avg_h = rate_sum * 16 / win_fill;
      if (avg_h < cfg_min_hr * 16 || avg_p < cfg_min_p * 16 || avg_p >= cfg_max_p * 16)
         return 1'b0;
      mean.second          = SEC_W'(sec);
      mean.avg_power       = AVGP_W'(avg_p);
      mean.avg_heart_rate  = AVGH_W'(avg_h);
      mean.window_overflow = overflowed;
      return 1'b1;
   endfunction

   function automatic stim_row_type sample_row(int unsigned t, int unsigned hr,
                                               int unsigned p);
      stim_row_type row;
      row = '0;
      row.beat.opcode      = OP_SAMPLE;
      row.beat.sample_time = TIME_W'(t);
      row.beat.heart_rate  = HR_W'(hr);
      row.beat.power       = PWR_W'(p);
      row.beat.now_second  = SEC_W'($urandom);
      return row;
   endfunction

   function automatic stim_row_type tick_row(int unsigned s, bit emits,
                                             int unsigned ap, int unsigned ah);
      stim_row_type row;
      row = '0;
      row.beat.opcode      = OP_TICK;
      row.beat.sample_time = TIME_W'($urandom);
      row.beat.heart_rate  = HR_W'($urandom);
      row.beat.power       = PWR_W'($urandom);
      row.beat.now_second  = SEC_W'(s);
      row.emits                = emits;
      row.mean.second          = SEC_W'(s);
      row.mean.avg_power       = AVGP_W'(ap);
      row.mean.avg_heart_rate  = AVGH_W'(ah);
      return row;
   endfunction

   function automatic void check_field(string field, logic [31:0] want,
                                       logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // fixed rows carry their own expectation; the rest go by the predictor
   task automatic send_beat(input req_item_type beat, input bit fixed,
                            input bit emits, input mean_pair_type mean);
      mean_pair_type forecast;
      bit hit;
      @(negedge clock);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= beat.opcode;
      req_ch.sample_time <= beat.sample_time;
      req_ch.heart_rate  <= beat.heart_rate;
      req_ch.power       <= beat.power;
      req_ch.now_second  <= beat.now_second;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      hit = advance_window(beat, forecast);
      if (fixed) begin
         if (emits) expected_means.push_back(mean);
      end else if (hit) begin
         expected_means.push_back(forecast);
      end
      beats_sent++;
   endtask

   task automatic push_sample(int unsigned t, int unsigned hr, int unsigned p);
      stim_row_type row;
      row = sample_row(t, hr, p);
      send_beat(row.beat, 1'b0, 1'b0, '0);
   endtask

   task automatic push_tick(int unsigned s);
      stim_row_type row;
      row = tick_row(s, 1'b0, 0, 0);
      send_beat(row.beat, 1'b0, 1'b0, '0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
   endtask

   // a tick with no result may still be walking the window
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SMOOTH_SECONDS: cfg_smooth = SMOOTH_W'(value);
         CSR_MIN_HEART_RATE: cfg_min_hr = HR_W'(value);
         CSR_MIN_POWER:      cfg_min_p  = PWR_W'(value);
         CSR_MAX_POWER:      cfg_max_p  = PWR_W'(value);
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned smooth, int unsigned min_hr,
                            int unsigned min_p, int unsigned max_p);
      settle();
      write_csr(CSR_SMOOTH_SECONDS, smooth);
      write_csr(CSR_MIN_HEART_RATE, min_hr);
      write_csr(CSR_MIN_POWER, min_p);
      write_csr(CSR_MAX_POWER, max_p);
   endtask

   // mostly inside the pass band, so that means tend to pass
   function automatic int unsigned rand_rate();
      if ($urandom_range(0, 9) < 8) return $urandom_range(cfg_min_hr, 255);
      return $urandom_range(0, 255);
   endfunction

   function automatic int unsigned rand_power();
      if (cfg_max_p > cfg_min_p && $urandom_range(0, 9) < 8)
         return $urandom_range(cfg_min_p, cfg_max_p - 1);
      return $urandom_range(0, 4095);
   endfunction

   // one closed second: a few samples in order, then its tick
   task automatic run_second();
      int unsigned count;
      int unsigned frac;
      count = $urandom_range(0, 4);
      frac  = $urandom_range(0, 3);
      repeat (count) begin
         push_sample(second_now * 16 + frac, rand_rate(), rand_power());
         frac += $urandom_range(0, 4);
         if (frac > 15) frac = 15;
      end
      push_tick(($urandom_range(0, 7) == 0) ? second_now + 1 : second_now);
      second_now += $urandom_range(1, 3);
   endtask

   task automatic run_noise();
      if ($urandom_range(0, 1))
         push_sample($urandom_range(0, second_now * 16 + 15), $urandom_range(0, 255),
                     $urandom_range(0, 4095));
      else if ($urandom_range(0, 1))
         push_tick($urandom_range(0, second_now + 5));
      else
         push_tick($urandom_range(0, 20'hFFFFF));
   endtask

   task automatic run_items(int unsigned count, bit pause);
      int unsigned start;
      start = beats_sent;
      while (beats_sent - start < count) begin
         if (pause && beats_sent - start >= count / 2) begin
            pause = 1'b0;
            drain_results();
         end
         if ($urandom_range(0, 99) < 85) run_second();
         else run_noise();
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_SMOOTH_SECONDS;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_SAMPLE;
      req_ch.sample_time = '0;
      req_ch.heart_rate  = '0;
      req_ch.power       = '0;
      req_ch.now_second  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default settings: window 0 s, band hr >= 50, 50 <= power < 500
      directed_rows.push_back(tick_row(0, 1'b0, 0, 0));
      directed_rows.push_back(sample_row(24'h000010, 100, 200));
      directed_rows.push_back(sample_row(24'h00001F, 120, 300));
      directed_rows.push_back(tick_row(1, 1'b1, 4000, 1760));
      directed_rows.push_back(tick_row(2, 1'b0, 0, 0));
      directed_rows.push_back(sample_row(24'h000020, 0, 0));
      directed_rows.push_back(tick_row(2, 1'b0, 0, 0));
      directed_rows.push_back(sample_row(24'h000030, 255, 4095));
      directed_rows.push_back(tick_row(3, 1'b0, 0, 0));
      directed_rows.push_back(sample_row(24'h000040, 60, 50));
      directed_rows.push_back(tick_row(4, 1'b1, 800, 960));
      directed_rows.push_back(sample_row(24'h000050, 50, 500));
      directed_rows.push_back(tick_row(5, 1'b0, 0, 0));
      directed_rows.push_back(sample_row(24'h000055, 51, 499));
      directed_rows.push_back(tick_row(5, 1'b1, 7992, 808));
      directed_rows.push_back(sample_row(24'h00005A, 52, 61));
      directed_rows.push_back(tick_row(5, 1'b1, 5653, 816));
      directed_rows.push_back(tick_row(604801, 1'b0, 0, 0));
      directed_rows.push_back(tick_row(20'hFFFFF, 1'b0, 0, 0));
      directed_rows.push_back(sample_row(24'h93A7FF, 100, 100));
      directed_rows.push_back(tick_row(604799, 1'b1, 1600, 1600));
      directed_rows.push_back(sample_row(24'h000000, 70, 70));
      directed_rows.push_back(tick_row(604799, 1'b1, 1360, 1360));
      directed_rows.push_back(tick_row(604800, 1'b0, 0, 0));
      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, 1'b1, directed_rows[i].emits,
                   directed_rows[i].mean);

      second_now = 0;
      configure(600, 0, 0, 4095);
      run_items(50, 1'b0);

      // hold the result side off while beats keep coming
      configure(0, 0, 0, 4095);
      rsp_hold_pending = 1'b1;
      run_items(70, 1'b1);

      configure(3, 255, 0, 4095);
      run_items(70, 1'b0);

      configure(10, 40, 4095, 0);
      run_items(40, 1'b0);

      repeat (3) begin
         int unsigned lo;
         lo = $urandom_range(0, 2000);
         configure($urandom_range(0, 20), $urandom_range(0, 150), lo,
                   $urandom_range(lo + 1, 4095));
         run_items(60, 1'b0);
      end

      // jump far ahead so that earlier samples fall out of the window
      second_now = $urandom_range(300000, 600000);
      configure($urandom_range(0, 5), 0, 0, 4095);
      send_gaps  = 1'b0;
      rsp_stalls = 1'b0;
      run_items(60, 1'b0);

      settle();
      if (mismatches == 0) begin
         $display("** time_window_average_with_clip: PASSED **");
      end else begin
         $display("** time_window_average_with_clip: FAILED **");
      end
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_pending) begin
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_pending = 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      mean_pair_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_means.size() == 0) begin
            $error("result beat for second %0d with none expected", rsp_ch.out_second);
            mismatches++;
         end else begin
            want = expected_means.pop_front();
            check_field("out_second", want.second, rsp_ch.out_second);
            check_field("avg_power", want.avg_power, rsp_ch.avg_power);
            check_field("avg_heart_rate", want.avg_heart_rate, rsp_ch.avg_heart_rate);
            check_field("window_overflow", want.window_overflow, rsp_ch.window_overflow);
         end
      end
   end

   initial begin
      #10ms;
      $display("** time_window_average_with_clip: FAILED **");
      $finish;
   end

endmodule
